>>> hw/rtl/dch_pkg.sv
// Shared types, codes and constants for the HTTP response body dechunker.
package dch_pkg;

    localparam int LEN_BITS_DEF = 32;

    // The queue between the classifier and the decoder.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;
    localparam logic [7:0] CH_T  = 8'h54;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_HEADER = 2'd1;
    localparam logic [1:0] ST_SATURATED = 2'd2;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_PLAIN,
        PH_LEN,
        PH_SKIP,
        PH_DATA,
        PH_DONE
    } phase_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } raw_item_t;

    typedef struct packed {
        logic [7:0] body_byte;
        logic       byte_valid;
        logic       end_of_body;
        logic [1:0] status;
    } body_item_t;

    // A raw byte together with the properties the decoder tests it for.
    typedef struct packed {
        logic [7:0] byte_val;
        logic       last;
        logic       is_hex;
        logic [3:0] hex_val;
        logic       is_cr;
        logic       is_lf;
        logic       is_t;
    } cls_item_t;

endpackage

>>> hw/rtl/dch_front.sv
// Input stage of the dechunker: registers each raw byte and classifies it.
module dch_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               raw_valid,
    output logic               raw_stall,
    input  dch_pkg::raw_item_t raw,
    input  logic               queue_full,
    output logic               push,
    output dch_pkg::cls_item_t push_item
);
    import dch_pkg::*;

    logic      front_valid_reg;
    logic      front_valid_next;
    cls_item_t front_item_reg;
    cls_item_t front_item_next;
    logic      accept;

    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    assign raw_stall = front_valid_reg && queue_full;
    assign accept    = raw_valid && !raw_stall;
    assign push      = front_valid_reg && !queue_full;
    assign push_item = front_item_reg;

    always_comb
    begin
        front_item_next          = front_item_reg;
        front_valid_next         = front_valid_reg;
        if (accept)
        begin
            front_valid_next         = 1'b1;
            front_item_next.byte_val = raw.in_byte;
            front_item_next.last     = raw.in_last;
            {front_item_next.is_hex, front_item_next.hex_val} = hex_decode(raw.in_byte);
            front_item_next.is_cr    = (raw.in_byte == CH_CR);
            front_item_next.is_lf    = (raw.in_byte == CH_LF);
            front_item_next.is_t     = (raw.in_byte == CH_T);
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_item_reg <= front_item_next;
    end

endmodule

>>> hw/rtl/dch_queue.sv
// Short queue of classified bytes between the input stage and the decoder.
module dch_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  dch_pkg::cls_item_t push_item,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output dch_pkg::cls_item_t head
);
    import dch_pkg::*;

    cls_item_t          entries [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QCNT_W-1:0]  count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    // The depth is a power of two, so the pointers simply wrap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_item;
        end
    end

endmodule

>>> hw/rtl/dch_back.sv
// Decoder of the dechunker: header scan, chunk framing and the result register.
module dch_back #(
    parameter int LEN_BITS = dch_pkg::LEN_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                head_valid,
    input  dch_pkg::cls_item_t  head,
    output logic                pop,
    output logic                body_valid,
    input  logic                body_stall,
    output dch_pkg::body_item_t body
);
    import dch_pkg::*;

    localparam logic [4:0] MARK_LAST = 5'd25;

    phase_t              phase_reg;
    phase_t              phase_next;
    logic [1:0]          blank_reg;
    logic [1:0]          blank_next;
    logic [4:0]          mark_reg;
    logic [4:0]          mark_next;
    logic                chunked_reg;
    logic                chunked_next;
    logic [LEN_BITS-1:0] remain_reg;
    logic [LEN_BITS-1:0] remain_next;
    logic [1:0]          skip_reg;
    logic [1:0]          skip_next;
    logic                ovf_reg;
    logic                ovf_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    body_item_t          out_item_reg;
    body_item_t          out_item_next;
    logic                take;
    logic                emit;
    logic                blank_hit;

    function automatic logic [7:0] marker_char(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = "T";
            5'd1:    ch = "r";
            5'd2:    ch = "a";
            5'd3:    ch = "n";
            5'd4:    ch = "s";
            5'd5:    ch = "f";
            5'd6:    ch = "e";
            5'd7:    ch = "r";
            5'd8:    ch = "-";
            5'd9:    ch = "E";
            5'd10:   ch = "n";
            5'd11:   ch = "c";
            5'd12:   ch = "o";
            5'd13:   ch = "d";
            5'd14:   ch = "i";
            5'd15:   ch = "n";
            5'd16:   ch = "g";
            5'd17:   ch = ":";
            5'd18:   ch = " ";
            5'd19:   ch = "c";
            5'd20:   ch = "h";
            5'd21:   ch = "u";
            5'd22:   ch = "n";
            5'd23:   ch = "k";
            5'd24:   ch = "e";
            5'd25:   ch = "d";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // The queue head is consumed whenever the result register can take a result.
    assign take       = head_valid && (!out_valid_reg || !body_stall);
    assign pop        = take;
    assign body_valid = out_valid_reg;
    assign body       = out_item_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        blank_next     = blank_reg;
        mark_next      = mark_reg;
        chunked_next   = chunked_reg;
        remain_next    = remain_reg;
        skip_next      = skip_reg;
        ovf_next       = ovf_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && body_stall;
        emit           = 1'b0;
        blank_hit      = blank_reg[0] ? head.is_lf : head.is_cr;

        if (take)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (!chunked_reg)
                    begin
                        if (head.byte_val == marker_char(mark_reg))
                        begin
                            if (mark_reg == MARK_LAST)
                            begin
                                chunked_next = 1'b1;
                                mark_next    = 5'd0;
                            end
                            else
                            begin
                                mark_next = mark_reg + 5'd1;
                            end
                        end
                        else
                        begin
                            mark_next = {4'd0, head.is_t};
                        end
                    end
                    if (blank_hit)
                    begin
                        if (blank_reg == 2'd3)
                        begin
                            blank_next  = 2'd0;
                            remain_next = '0;
                            phase_next  = chunked_next ? PH_LEN : PH_PLAIN;
                        end
                        else
                        begin
                            blank_next = blank_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        blank_next = {1'b0, head.is_cr};
                    end
                end
                PH_PLAIN:
                begin
                    emit = 1'b1;
                end
                PH_LEN:
                begin
                    if (head.is_hex)
                    begin
                        // Another digit would overflow once the top nibble is in use.
                        if (remain_reg[LEN_BITS-1 -: 4] != 4'd0)
                        begin
                            remain_next = '1;
                            ovf_next    = 1'b1;
                        end
                        else
                        begin
                            remain_next = {remain_reg[LEN_BITS-5:0], head.hex_val};
                        end
                    end
                    else if (remain_reg == '0)
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        skip_next  = 2'd1;
                        phase_next = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    if (skip_reg > 2'd1)
                    begin
                        skip_next = skip_reg - 2'd1;
                    end
                    else
                    begin
                        skip_next  = 2'd0;
                        phase_next = (remain_reg != '0) ? PH_DATA : PH_LEN;
                    end
                end
                PH_DATA:
                begin
                    emit = 1'b1;
                    if (remain_reg > LEN_BITS'(1))
                    begin
                        remain_next = remain_reg - LEN_BITS'(1);
                    end
                    else
                    begin
                        remain_next = '0;
                        skip_next   = 2'd2;
                        phase_next  = PH_SKIP;
                    end
                end
                default:
                begin
                end
            endcase

            if (emit || head.last)
            begin
                out_valid_next            = 1'b1;
                out_item_next.body_byte   = emit ? head.byte_val : 8'h00;
                out_item_next.byte_valid  = emit;
                out_item_next.end_of_body = head.last;
                if (phase_next == PH_HEADER)
                begin
                    out_item_next.status = ST_NO_HEADER;
                end
                else if (ovf_next)
                begin
                    out_item_next.status = ST_SATURATED;
                end
                else
                begin
                    out_item_next.status = ST_OK;
                end
            end

            // The final byte of a response leaves the decoder ready for the next one.
            if (head.last)
            begin
                phase_next   = PH_HEADER;
                blank_next   = 2'd0;
                mark_next    = 5'd0;
                chunked_next = 1'b0;
                remain_next  = '0;
                skip_next    = 2'd0;
                ovf_next     = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            blank_reg     <= 2'd0;
            mark_reg      <= 5'd0;
            chunked_reg   <= 1'b0;
            remain_reg    <= '0;
            skip_reg      <= 2'd0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            blank_reg     <= blank_next;
            mark_reg      <= mark_next;
            chunked_reg   <= chunked_next;
            remain_reg    <= remain_next;
            skip_reg      <= skip_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

>>> hw/rtl/http_response_body_dechunker.sv
// HTTP response body dechunker: the raw response goes in a byte per request and
// the decoded body comes out a byte per request.
//
// The raw channel (raw_valid, raw_stall, raw) takes one response byte per request,
// with in_last set on the final byte. The body channel (body_valid, body_stall,
// body) gives one request for every body byte and one for the final input byte;
// header bytes and chunk framing give none. end_of_body marks the request for the
// final byte, and status reports a missing header end or a saturated chunk length.
// A byte passes in turn through the input register, the queue and the result
// register. One byte is taken in every cycle while raw_stall is low, and the
// decoder updates its state once for each byte it takes. While the receiver stalls,
// the result register, the queue and the input register fill up before raw_stall
// rises. Reset empties all stages and puts the decoder back into the header
// phase; the final byte of a response does the same for the decoder.
module http_response_body_dechunker #(
    parameter int LEN_BITS = dch_pkg::LEN_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                raw_valid,
    output logic                raw_stall,
    input  dch_pkg::raw_item_t  raw,
    output logic                body_valid,
    input  logic                body_stall,
    output dch_pkg::body_item_t body
);
    import dch_pkg::*;

    logic      push;
    cls_item_t push_item;
    logic      queue_full;
    logic      pop;
    logic      head_valid;
    cls_item_t head;

    dch_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw_valid  (raw_valid),
        .raw_stall  (raw_stall),
        .raw        (raw),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    dch_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (queue_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    dch_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .body_valid (body_valid),
        .body_stall (body_stall),
        .body       (body)
    );

    // A body byte is only produced once the header has ended.
    assert property (@(posedge clk) disable iff (!rst_n)
        body_valid && body.byte_valid |-> body.status != ST_NO_HEADER)
        else $error("body byte reported with header end missing");

    // Every result carries a body byte or closes the response.
    assert property (@(posedge clk) disable iff (!rst_n)
        body_valid |-> body.byte_valid || body.end_of_body)
        else $error("empty result emitted");

    // A result without a body byte carries a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        body_valid && !body.byte_valid |-> body.body_byte == 8'h00)
        else $error("non-zero byte on a result without a body byte");

    // The queue only pops what the decoder has seen as present.
    assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue popped while empty");

endmodule
